/* rtl/core/att_pkg.sv */
// ----------------------------------------------------------------------------
// att_pkg: shared constants for the accelerometer tilt block
// sample width, cordic step count and the arctangent table in degrees q16
// ----------------------------------------------------------------------------
package att_pkg;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 20;
	localparam int ANG_W            = 11;
	localparam int THR_W            = 8;
	localparam int Z_W              = 26;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_THRESH = 1'b1;

	function automatic logic [Z_W-1:0] atan_deg_q16(input logic [4:0] i);
		logic [Z_W-1:0] r;
		unique case (i)
			5'd0:  r = 26'd2949120;
			5'd1:  r = 26'd1740967;
			5'd2:  r = 26'd919879;
			5'd3:  r = 26'd466945;
			5'd4:  r = 26'd234379;
			5'd5:  r = 26'd117304;
			5'd6:  r = 26'd58666;
			5'd7:  r = 26'd29335;
			5'd8:  r = 26'd14668;
			5'd9:  r = 26'd7334;
			5'd10: r = 26'd3667;
			5'd11: r = 26'd1833;
			5'd12: r = 26'd917;
			5'd13: r = 26'd458;
			5'd14: r = 26'd229;
			5'd15: r = 26'd115;
			5'd16: r = 26'd57;
			5'd17: r = 26'd29;
			5'd18: r = 26'd14;
			5'd19: r = 26'd7;
			5'd20: r = 26'd4;
			5'd21: r = 26'd2;
			5'd22: r = 26'd1;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

/* rtl/core/accel_tilt_threshold.sv */
// ----------------------------------------------------------------------------
// accel_tilt_threshold: roll and pitch from one accelerometer sample
// square root and cordic units run twice per calibrated, enabled sample under a small sequencer
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_valid / cfg_ready
//
// a calibrated, enabled sample passes twice through the shared sqrt and cordic, first for
// roll and then for pitch, before out_valid rises; the next sample is taken only once the
// result beat has been taken and the sequencer is back in idle
// a held sample goes straight to the output state; reset sets enable=1, threshold=100, angles 0
// in_stall stays high from acceptance until the result beat is taken
module accel_tilt_threshold #(
	parameter int SAMPLE_BITS  = att_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = att_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       accel_x,
	input  logic signed [SAMPLE_BITS-1:0]       accel_y,
	input  logic signed [SAMPLE_BITS-1:0]       accel_z,
	input  logic                                calibrated,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [att_pkg::ANG_W-1:0]    roll_scaled,
	output logic signed [att_pkg::ANG_W-1:0]    pitch_scaled,
	output logic                                updated,
	output logic                                over_threshold,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [att_pkg::THR_W-1:0]           cfg_data
);
	import att_pkg::*;

	localparam int SQW = 2 * SAMPLE_BITS + 1;
	localparam int RTW = SQW / 2 + 1;
	localparam int MW  = 2 * SAMPLE_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQ, ST_ROOT, ST_CORD, ST_OUT
	} state_t;

	state_t state_q;
	logic   pass_q;
	logic   enable_q;
	logic [THR_W-1:0] thr_q;
	logic signed [SAMPLE_BITS-1:0] ax_q, ay_q, az_q;
	logic signed [ANG_W-1:0] roll_q, pitch_q;
	logic [SQW-1:0] sum_q;
	logic sq_start, sq_done, co_start, co_done;
	logic [RTW-1:0] root;
	logic signed [ANG_W-1:0] co_scaled;
	logic signed [SAMPLE_BITS:0] num;
	logic signed [MW-1:0] sq_a, sq_z;
	logic [ANG_W-1:0] mag_r, mag_p;

	assign cfg_ready = (state_q == ST_IDLE) && !in_valid;
	assign in_stall  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			thr_q    <= THR_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_THRESH: thr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sq_a = ax_q * ax_q;
	assign sq_z = az_q * az_q;
	assign num  = pass_q ? $signed({ay_q[SAMPLE_BITS-1], ay_q})
		: -$signed({ax_q[SAMPLE_BITS-1], ax_q});
	assign sq_start = (state_q == ST_SQ);
	assign co_start = (state_q == ST_ROOT) && sq_done;

	att_isqrt #(.IN_W(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.operand(sum_q), .done(sq_done), .root(root)
	);

	att_cordic #(.SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(co_start),
		.num(num),
		.den(root[SAMPLE_BITS:0]), .done(co_done), .scaled(co_scaled)
	);

	assign mag_r = roll_q[ANG_W-1] ? ANG_W'(-roll_q) : ANG_W'(roll_q);
	assign mag_p = pitch_q[ANG_W-1] ? ANG_W'(-pitch_q) : ANG_W'(pitch_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pass_q    <= 1'b0;
			out_valid <= 1'b0;
			roll_q    <= '0;
			pitch_q   <= '0;
			updated   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					ax_q   <= accel_x;
					ay_q   <= accel_y;
					az_q   <= accel_z;
					pass_q <= 1'b0;
					if (enable_q && calibrated) begin
						state_q <= ST_SQ;
						sum_q   <= SQW'(accel_y * accel_y) + SQW'(accel_z * accel_z);
						updated <= 1'b1;
					end else begin
						state_q   <= ST_OUT;
						updated   <= 1'b0;
						out_valid <= 1'b1;
					end
				end
				ST_SQ:   state_q <= ST_ROOT;
				ST_ROOT: if (sq_done) state_q <= ST_CORD;
				ST_CORD: if (co_done) begin
					if (!pass_q) begin
						roll_q  <= co_scaled;
						pass_q  <= 1'b1;
						sum_q   <= SQW'(sq_a) + SQW'(sq_z);
						state_q <= ST_SQ;
					end else begin
						pitch_q   <= co_scaled;
						state_q   <= ST_OUT;
						out_valid <= 1'b1;
					end
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign roll_scaled    = roll_q;
	assign pitch_scaled   = pitch_q;
	assign over_threshold = updated && ((mag_r > ANG_W'(thr_q)) || (mag_p > ANG_W'(thr_q)));

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("out beat outside output state");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(roll_scaled) && $stable(pitch_scaled))
		else $error("result changed while stalled");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !updated |-> !over_threshold) else $error("flag on held result");
endmodule

/* rtl/core/att_isqrt.sv */
// ----------------------------------------------------------------------------
// att_isqrt: bit-pair restoring integer square root
// one result bit per cycle, floor of sqrt of an unsigned operand
// ----------------------------------------------------------------------------
module att_isqrt #(
	parameter int IN_W = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     operand,
	output logic                done,
	output logic [IN_W/2:0]     root
);
	localparam int RW  = IN_W / 2 + 1;
	localparam int VW  = 2 * RW;
	localparam int CW  = $clog2(RW + 1);

	logic [VW-1:0] v_q;
	logic [VW-1:0] rem_q;
	logic [RW-1:0] res_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [RW+1:0] trial;
	logic [RW+1:0] rem_next;
	logic [RW+1:0] rem_cat;

	assign rem_cat = {rem_q[RW-1:0], v_q[VW-1 -: 2]};
	assign trial   = {res_q, 2'b01};
	assign rem_next = rem_cat - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= VW'(operand);
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[VW-3:0], 2'b00};
			if (rem_cat >= trial) begin
				rem_q <= VW'(rem_next);
				res_q <= {res_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= VW'(rem_cat);
				res_q <= {res_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root = res_q;
endmodule

/* rtl/core/att_cordic.sv */
// ----------------------------------------------------------------------------
// att_cordic: iterative vectoring cordic
// one micro-rotation per cycle, returns clamped whole degrees times minus ten
// ----------------------------------------------------------------------------
module att_cordic #(
	parameter int SAMPLE_BITS  = att_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = att_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS:0]   num,
	input  logic        [SAMPLE_BITS:0]   den,
	output logic                          done,
	output logic signed [att_pkg::ANG_W-1:0] scaled
);
	import att_pkg::*;

	localparam int DW    = SAMPLE_BITS + 20;
	localparam int STEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam int CW    = 6;

	logic signed [DW-1:0]  x_q, y_q;
	logic signed [Z_W+1:0] z_q;
	logic [CW-1:0]         i_q;
	logic                  busy_q;
	logic                  zero_q;
	logic signed [DW-1:0]  xs, ys;
	logic signed [Z_W+1:0] zt, za;
	logic signed [Z_W+1:0] dq;
	logic signed [7:0]     deg;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign zt = $signed({2'b00, atan_deg_q16(i_q[4:0])});

	assign za  = z_q[Z_W+1] ? -z_q : z_q;
	assign dq  = za >>> 16;

	always_comb begin
		logic signed [Z_W+1:0] d;
		d = z_q[Z_W+1] ? -dq : dq;
		if (zero_q) deg = '0;
		else if (d > 90) deg = 8'sd90;
		else if (d < -90) deg = -8'sd90;
		else deg = 8'(d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({{(DW-SAMPLE_BITS-17){1'b0}}, den, 16'h0000});
			y_q    <= $signed({{(DW-SAMPLE_BITS-17){num[SAMPLE_BITS]}}, num, 16'h0000});
			z_q    <= '0;
			zero_q <= (num == '0) && (den == '0);
		end else if (busy_q) begin
			if (!y_q[DW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + zt;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - zt;
			end
		end
	end

	assign scaled = ANG_W'(-(ANG_W'(deg) * 11'sd10));
endmodule

/* sim/tb_accel_tilt_threshold.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_threshold: self-checking bench for the tilt angle block
// drives samples in random bursts, computes roll and pitch with an own
// square root and cordic model, and compares every result beat in order
// ----------------------------------------------------------------------------
module tb_accel_tilt_threshold;
	import att_pkg::*;

	typedef struct packed {
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
		logic                    upd;
		logic                    over;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic calibrated = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ANG_W-1:0] roll_scaled, pitch_scaled;
	logic updated, over_threshold;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [THR_W-1:0] cfg_data = '0;

	tilt_t tilt_q[$];
	int errors = 0;
	logic en_m;
	logic [7:0] thr_m;
	int roll_m, pitch_m;

	accel_tilt_threshold i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("accel_tilt_threshold: mismatch");
		$finish;
	end

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res = 0, bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic int tilt_deg(longint num, longint den);
		longint x, y, z, xs, ys, d;
		longint atab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		if (num == 0 && den == 0) return 0;
		x = den * 65536;
		y = num * 65536;
		z = 0;
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += atab[i];
			end else begin
				x = x - ys; y = y + xs; z -= atab[i];
			end
		end
		d = z / 65536;
		if (d > 90) d = 90;
		if (d < -90) d = -90;
		return int'(d);
	endfunction

	function automatic tilt_t predict_tilt(logic signed [15:0] ax, ay, az, logic cal);
		tilt_t t;
		longint x = ax, y = ay, z = az;
		int ra, pa;
		t.upd = 1'b0;
		t.over = 1'b0;
		if (en_m && cal) begin
			roll_m = -10 * tilt_deg(-x, int_sqrt(y * y + z * z));
			pitch_m = -10 * tilt_deg(y, int_sqrt(x * x + z * z));
			ra = roll_m < 0 ? -roll_m : roll_m;
			pa = pitch_m < 0 ? -pitch_m : pitch_m;
			t.upd = 1'b1;
			t.over = (ra > thr_m) || (pa > thr_m);
		end
		t.roll = ANG_W'(roll_m);
		t.pitch = ANG_W'(pitch_m);
		return t;
	endfunction

	task automatic send_sample(logic signed [15:0] ax, ay, az, logic cal);
		in_valid <= 1'b1;
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		calibrated <= cal;
		do @(posedge clk); while (in_stall);
		tilt_q.push_back(predict_tilt(ax, ay, az, cal));
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (tilt_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ENABLE) en_m = val[0];
		else thr_m = val;
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3: return 16'($urandom_range(0, 400) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver stall pattern, with quiet stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 99) < 50) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		tilt_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tilt_q.size() == 0) begin
				$display("%t unexpected beat roll=%0d pitch=%0d", $time, roll_scaled, pitch_scaled);
				errors++;
			end else begin
				e = tilt_q.pop_front();
				if (roll_scaled !== e.roll || pitch_scaled !== e.pitch ||
						updated !== e.upd || over_threshold !== e.over) begin
					$display("%t expected r=%0d p=%0d u=%0b o=%0b actual r=%0d p=%0d u=%0b o=%0b",
						$time, e.roll, e.pitch, e.upd, e.over,
						roll_scaled, pitch_scaled, updated, over_threshold);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_sample(0, 0, 0, 1);
		send_sample(16'sh7fff, 0, 0, 1);
		send_sample(16'sh8000, 0, 0, 1);
		send_sample(0, 16'sh7fff, 0, 1);
		send_sample(0, 16'sh8000, 0, 1);
		send_sample(0, 0, 16'sh7fff, 1);
		send_sample(0, 0, 16'sh8000, 1);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
		send_sample(100, -100, 16384, 1);
		send_sample(-5000, 3000, 0, 0);
		send_sample(1, 1, 1, 1);
		send_sample(-1, -1, 0, 1);
	endtask

	task automatic test_thresholds();
		write_reg(REG_THRESH, 8'd0);
		send_sample(0, 0, 1000, 1);
		send_sample(300, 0, 16000, 1);
		write_reg(REG_THRESH, 8'd255);
		send_sample(16000, 16000, 1000, 1);
		send_sample(4000, 0, 16000, 1);
		write_reg(REG_THRESH, 8'd10);
		send_sample(300, -300, 16000, 1);
	endtask

	task automatic test_disabled();
		write_reg(REG_ENABLE, 1'b0);
		repeat (4) send_sample(rand_axis(), rand_axis(), rand_axis(), 1'($urandom));
		write_reg(REG_ENABLE, 1'b1);
	endtask

	task automatic test_random();
		for (int n = 0; n < 1800; n++) begin
			if (n % 300 == 299) begin
				write_reg(REG_THRESH, 8'($urandom));
				write_reg(REG_ENABLE, ($urandom_range(0, 3) != 0));
			end
			send_sample(rand_axis(), rand_axis(), rand_axis(), ($urandom_range(0, 9) != 0));
		end
	endtask

	initial begin
		en_m = 1'b1;
		thr_m = 8'd100;
		roll_m = 0;
		pitch_m = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_thresholds();
		test_disabled();
		test_random();
		in_valid <= 1'b0;
		while (tilt_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("accel_tilt_threshold: match");
		else $display("accel_tilt_threshold: mismatch");
		$finish;
	end
endmodule
